// ===== hdl/rlf_pkg.sv =====
// Package for the RGB LED two-phase fader.
// Beat payload structs, divider request/response structs and shared constants.
// No dependencies.
`default_nettype none

package rlf_pkg;

  // Channel count and channel index width
  localparam int NUM_CH = 3;
  localparam int CH_W   = 2;

  // Side and mode codes
  localparam logic [1:0] RING_SIDE = 2'd0;
  localparam logic       MODE_CMD  = 1'b0;
  localparam logic       MODE_TICK = 1'b1;

  // Serial divider: one quotient bit per step, quotient fits in a level
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;

  // Input beat
  typedef struct packed {
    logic        mode;
    logic [1:0]  side;
    logic [7:0]  red_target;
    logic [7:0]  green_target;
    logic [7:0]  blue_target;
    logic [15:0] fade_ms;
    logic [31:0] now_ms;
  } in_t;

  // Output beat
  typedef struct packed {
    logic       light_write;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic       fading;
  } out_t;

  // Divider request: numerator is level delta times elapsed time
  typedef struct packed {
    logic        start;
    logic [23:0] numer;
    logic [15:0] denom;
  } div_req_t;

  // Divider response
  typedef struct packed {
    logic       done;
    logic [7:0] quot;
    logic       rem_nz;
  } div_res_t;

endpackage

`default_nettype wire

// ===== hdl/rlf_divider.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Needs numer < 256 * denom so the quotient fits in 8 bits. Uses rlf_pkg.
`default_nettype none

module rlf_divider
  import rlf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_res_t      res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [15:0]          den_r, den_nxt;
  logic [7:0]           num_r, num_nxt;
  logic [7:0]           quot_r, quot_nxt;

  logic [16:0] trial;
  logic        ge;

  // One trial subtract per step
  assign trial = {rem_r, num_r[7]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    quot_nxt = quot_r;
    if (req.start) begin
      // upper part is already below the divisor
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.numer[23:8];
      num_nxt  = req.numer[7:0];
      den_nxt  = req.denom;
      quot_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? 16'(trial - {1'b0, den_r}) : trial[15:0];
      num_nxt  = {num_r[6:0], 1'b0};
      quot_nxt = {quot_r[6:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done   = done_r;
  assign res.quot   = quot_r;
  assign res.rem_nz = |rem_r;

endmodule

`default_nettype wire

// ===== hdl/rgb_led_two_phase_fader_core.sv =====
// Path: a beat is captured in S_IDLE, evaluated in S_EVAL and loaded into the
// output register from S_EMIT once the output is free; an interpolating tick
// also visits S_CH per channel and S_DIV per moving channel (8-step divider).
// Throughput: one item at a time; the next beat is taken once the result is
// in the output register. Synchronous active-low reset clears levels and state.
`default_nettype none

module rgb_led_two_phase_fader_core
  import rlf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_CH   = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]      state_r;
  logic [CH_W-1:0] ch_r;
  in_t             item_r;
  logic            write_r;
  logic [15:0]     elapsed_r;

  logic [7:0]  lvl_now_r  [NUM_CH];
  logic [7:0]  lvl_from_r [NUM_CH];
  logic [7:0]  lvl_goal_r [NUM_CH];
  logic [31:0] phase_start_r;
  logic [15:0] phase_len_r;
  logic        split_r;
  logic        second_r;
  logic        active_r;

  logic out_valid_r;
  out_t out_r;

  div_req_t div_req;
  div_res_t div_res;

  // Command targets as an array
  logic [7:0] tgt [NUM_CH];
  assign tgt[0] = item_r.red_target;
  assign tgt[1] = item_r.green_target;
  assign tgt[2] = item_r.blue_target;

  // Direction check across channels for a new command
  logic up, down;
  always_comb begin
    up   = 1'b0;
    down = 1'b0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (tgt[i] > lvl_now_r[i]) up = 1'b1;
      if (tgt[i] < lvl_now_r[i]) down = 1'b1;
    end
  end

  // Elapsed time for a tick
  logic [31:0] elapsed;
  logic        in_phase;
  assign elapsed  = item_r.now_ms - phase_start_r;
  assign in_phase = elapsed < {16'd0, phase_len_r};

  // Per-channel interpolation operands
  logic [7:0]  cur_from, cur_goal, cur_delta;
  logic        cur_rise, cur_move;
  logic [23:0] product;
  always_comb begin
    cur_from  = lvl_from_r[ch_r];
    cur_goal  = lvl_goal_r[ch_r];
    cur_rise  = cur_goal >= cur_from;
    cur_delta = cur_rise ? cur_goal - cur_from : cur_from - cur_goal;
    product   = 24'(cur_delta) * 24'(elapsed_r);
    if (!split_r)      cur_move = 1'b1;
    else if (!second_r) cur_move = cur_goal > cur_from;
    else               cur_move = cur_goal < cur_from;
  end

  assign div_req.start = (state_r == S_CH) && cur_move;
  assign div_req.numer = product;
  assign div_req.denom = phase_len_r;

  rlf_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // Step floored on the way up, ceiled on the way down
  logic [7:0] blended;
  assign blended = cur_rise ? cur_from + div_res.quot
                            : cur_from - (div_res.quot + 8'(div_res.rem_nz));

  logic emit_ok;
  assign emit_ok = !out_valid_r || !out_stall;

  // Sequencer and fade state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ch_r          <= '0;
      write_r       <= 1'b0;
      phase_start_r <= '0;
      phase_len_r   <= '0;
      split_r       <= 1'b0;
      second_r      <= 1'b0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        lvl_now_r[i]  <= '0;
        lvl_from_r[i] <= '0;
        lvl_goal_r[i] <= '0;
      end
    end else begin
      // Output valid: set on emit, dropped once the beat is taken
      if (state_r == S_EMIT && emit_ok) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (item_r.mode == MODE_CMD) begin
            state_r <= S_EMIT;
            if (item_r.side == RING_SIDE) begin
              for (int i = 0; i < NUM_CH; i++) begin
                lvl_from_r[i] <= lvl_now_r[i];
                lvl_goal_r[i] <= tgt[i];
              end
              if (item_r.fade_ms != 16'd0) begin
                split_r       <= up && down;
                phase_start_r <= item_r.now_ms;
                phase_len_r   <= (up && down) ? item_r.fade_ms >> 1 : item_r.fade_ms;
                second_r      <= 1'b0;
                active_r      <= 1'b1;
                write_r       <= 1'b0;
              end else begin
                for (int i = 0; i < NUM_CH; i++) lvl_now_r[i] <= tgt[i];
                write_r  <= 1'b1;
                active_r <= 1'b0;
              end
            end else begin
              write_r <= 1'b0;
            end
          end else if (active_r) begin
            if (in_phase) begin
              // interpolate channel by channel
              elapsed_r <= elapsed[15:0];
              write_r   <= 1'b1;
              ch_r      <= '0;
              state_r   <= S_CH;
            end else if (split_r && !second_r) begin
              for (int i = 0; i < NUM_CH; i++) lvl_from_r[i] <= lvl_now_r[i];
              phase_start_r <= item_r.now_ms;
              second_r      <= 1'b1;
              write_r       <= 1'b0;
              state_r       <= S_EMIT;
            end else begin
              for (int i = 0; i < NUM_CH; i++) lvl_now_r[i] <= lvl_goal_r[i];
              write_r  <= 1'b1;
              active_r <= 1'b0;
              state_r  <= S_EMIT;
            end
          end else begin
            write_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_CH: begin
          if (cur_move) begin
            state_r <= S_DIV;
          end else if (ch_r == CH_W'(NUM_CH - 1)) begin
            state_r <= S_EMIT;
          end else begin
            ch_r <= ch_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            lvl_now_r[ch_r] <= blended;
            if (ch_r == CH_W'(NUM_CH - 1)) begin
              state_r <= S_EMIT;
            end else begin
              ch_r    <= ch_r + 1'b1;
              state_r <= S_CH;
            end
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Input capture and output register payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    if (state_r == S_EMIT && emit_ok) begin
      out_r.light_write <= write_r;
      out_r.red_level   <= lvl_now_r[0];
      out_r.green_level <= lvl_now_r[1];
      out_r.blue_level  <= lvl_now_r[2];
      out_r.fading      <= active_r;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // Divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == S_DIV)
    else $error("divider done outside wait state");

  // Channel index never passes the last channel
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r != 2'd3)
    else $error("channel index out of range");

  // A finished item always lands in the output register
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_ok) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not loaded into output register");

  // Only a tick inside a phase launches the divider
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (active_r && elapsed_r < phase_len_r))
    else $error("divider started outside an active phase");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for rgb_led_two_phase_fader_core: directed and random
// command/tick beats, checked against an in-bench fade predictor.
// Depends on rlf_pkg (hdl/rlf_pkg.sv) and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import rlf_pkg::*;

  // Pending input beat; drain holds it back until every result is in
  typedef struct {
    bit  drain;
    in_t beat;
  } pending_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  rgb_led_two_phase_fader_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pending_t beat_q[$];
  out_t     led_exp_q[$];

  int errors = 0;
  int beats_in = 0;
  int results_seen = 0;
  int writes_seen = 0;
  int split_fades = 0;
  int live_items = 0;

  // Fade predictor state
  logic [7:0]  lvl_now  [NUM_CH];
  logic [7:0]  lvl_from [NUM_CH];
  logic [7:0]  lvl_goal [NUM_CH];
  logic [31:0] ph_start;
  logic [15:0] ph_len;
  logic        split_on;
  logic        in_second;
  logic        fade_on;

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      lvl_now[i]  = '0;
      lvl_from[i] = '0;
      lvl_goal[i] = '0;
    end
    ph_start  = '0;
    ph_len    = '0;
    split_on  = 1'b0;
    in_second = 1'b0;
    fade_on   = 1'b0;
  end

  // from + floor((to - from) * e / len); falling channels round toward to
  function automatic logic [7:0] lerp_level(logic [7:0] from, logic [7:0] to,
                                            logic [31:0] e, logic [15:0] len);
    logic [31:0] span;
    logic [31:0] q;
    if (len == 16'd0) return to;
    if (to >= from) begin
      span = 32'(to) - 32'(from);
      q = (span * e) / 32'(len);
      return from + q[7:0];
    end
    span = 32'(from) - 32'(to);
    q = (span * e + 32'(len) - 32'd1) / 32'(len);
    return from - q[7:0];
  endfunction

  // Advance the predictor by one accepted beat and return the expected result
  function automatic out_t predict_led(in_t b);
    logic [7:0]  tgt [NUM_CH];
    logic        up;
    logic        down;
    logic        wr;
    logic        move;
    logic [31:0] elapsed;
    out_t        r;
    tgt[0] = b.red_target;
    tgt[1] = b.green_target;
    tgt[2] = b.blue_target;
    wr = 1'b0;
    up = 1'b0;
    down = 1'b0;
    if (b.mode == MODE_CMD) begin
      if (b.side == RING_SIDE) begin
        for (int i = 0; i < NUM_CH; i++) begin
          lvl_from[i] = lvl_now[i];
          lvl_goal[i] = tgt[i];
          if (tgt[i] > lvl_from[i]) up = 1'b1;
          if (tgt[i] < lvl_from[i]) down = 1'b1;
        end
        if (b.fade_ms != 16'd0) begin
          split_on = up && down;
          if (split_on) split_fades++;
          ph_start  = b.now_ms;
          ph_len    = split_on ? (b.fade_ms >> 1) : b.fade_ms;
          in_second = 1'b0;
          fade_on   = 1'b1;
        end else begin
          for (int i = 0; i < NUM_CH; i++) lvl_now[i] = tgt[i];
          wr = 1'b1;
          fade_on = 1'b0;
        end
      end
    end else if (fade_on) begin
      elapsed = b.now_ms - ph_start;
      if (elapsed < 32'(ph_len)) begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (!split_on) move = 1'b1;
          else if (!in_second) move = lvl_goal[i] > lvl_from[i];
          else move = lvl_goal[i] < lvl_from[i];
          if (move) lvl_now[i] = lerp_level(lvl_from[i], lvl_goal[i], elapsed, ph_len);
        end
        wr = 1'b1;
      end else if (split_on && !in_second) begin
        // first half done: restart from present levels for the falling half
        for (int i = 0; i < NUM_CH; i++) lvl_from[i] = lvl_now[i];
        ph_start  = b.now_ms;
        in_second = 1'b1;
      end else begin
        for (int i = 0; i < NUM_CH; i++) lvl_now[i] = lvl_goal[i];
        wr = 1'b1;
        fade_on = 1'b0;
      end
    end
    r.light_write = wr;
    r.red_level   = lvl_now[0];
    r.green_level = lvl_now[1];
    r.blue_level  = lvl_now[2];
    r.fading      = fade_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    $display("%0t: MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  task automatic queue_beat(logic m, logic [1:0] sd, logic [7:0] r, logic [7:0] g,
                            logic [7:0] bl, logic [15:0] f, logic [31:0] t, bit drain);
    pending_t p;
    p.drain = drain;
    p.beat.mode = m;
    p.beat.side = sd;
    p.beat.red_target = r;
    p.beat.green_target = g;
    p.beat.blue_target = bl;
    p.beat.fade_ms = f;
    p.beat.now_ms = t;
    beat_q.push_back(p);
    if (!(m == MODE_CMD && sd != RING_SIDE)) live_items++;
  endtask

  // Tick with random don't-care fields
  task automatic queue_tick(logic [31:0] t, bit drain);
    queue_beat(MODE_TICK, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               16'($urandom), t, drain);
  endtask

  function automatic logic [7:0] pick_level();
    int c;
    c = $urandom_range(0, 9);
    if (c < 2) return 8'h00;
    if (c < 4) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Input driver
  always @(posedge clk) begin : drive_beats
    bit       taken;
    bit       send;
    pending_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        led_exp_q.push_back(predict_led(in_data));
        beats_in++;
      end
      if (!(in_valid && !taken)) begin
        send = beat_q.size() != 0 &&
               ((beats_in >= 600 && beats_in < 760) || $urandom_range(0, 99) >= 25) &&
               (!beat_q[0].drain || led_exp_q.size() == 0);
        if (send) begin
          nxt = beat_q.pop_front();
          in_data  <= nxt.beat;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : watch_results
    out_t    want;
    bit      hold;
    int      hold_left;
    bit      hold_done;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_done = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.light_write) writes_seen++;
        if (led_exp_q.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data);
        end else begin
          want = led_exp_q.pop_front();
          if (out_data.light_write !== want.light_write)
            report_mismatch("light_write", want.light_write, out_data.light_write);
          if (out_data.red_level !== want.red_level)
            report_mismatch("red_level", want.red_level, out_data.red_level);
          if (out_data.green_level !== want.green_level)
            report_mismatch("green_level", want.green_level, out_data.green_level);
          if (out_data.blue_level !== want.blue_level)
            report_mismatch("blue_level", want.blue_level, out_data.blue_level);
          if (out_data.fading !== want.fading)
            report_mismatch("fading", want.fading, out_data.fading);
        end
      end
      // one long hold-off so the core backs up into its input
      if (!hold_done && results_seen == 150) begin
        hold_left = 400;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold = 1;
        hold_left--;
      end else if (results_seen >= 600 && results_seen < 760) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 99) < 25;
      end
      out_stall <= hold;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic [31:0] clock_ms;
    logic [31:0] t;
    logic [15:0] f;
    int          n_ticks;
    int          c;
    int          seq_no;

    // Idle tick straight out of reset, all other fields high
    queue_beat(MODE_TICK, 2'b11, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
    // Commands for the other sides leave the levels alone and write no LED
    for (int s = 0; s < 4; s++)
      if (2'(s) != RING_SIDE)
        queue_beat(MODE_CMD, 2'(s), 8'hFF, 8'hFF, 8'hFF, 16'd0, 32'd0, 0);
    // Immediate sets
    queue_beat(MODE_CMD, RING_SIDE, 8'hFF, 8'h00, 8'hFF, 16'd0, 32'd0, 0);
    queue_beat(MODE_CMD, RING_SIDE, 8'h00, 8'h00, 8'h00, 16'd0, 32'd0, 0);
    // Single-phase rising fade, first tick at elapsed zero, ends at the deadline
    queue_beat(MODE_CMD, RING_SIDE, 8'd200, 8'd100, 8'd50, 16'd1000, 32'd1000, 0);
    queue_tick(32'd1000, 0);
    queue_tick(32'd1500, 0);
    queue_tick(32'd1999, 0);
    queue_tick(32'd2000, 0);
    // Two-phase fade: green rises, red falls, blue stays
    queue_beat(MODE_CMD, RING_SIDE, 8'd0, 8'd255, 8'd50, 16'd1001, 32'd5000, 0);
    queue_tick(32'd5100, 0);
    queue_tick(32'd5500, 0);
    queue_tick(32'd5750, 0);
    queue_tick(32'd6000, 0);
    // Two-phase fade of 1 ms: zero-length phases
    queue_beat(MODE_CMD, RING_SIDE, 8'd255, 8'd0, 8'd50, 16'd1, 32'd7000, 0);
    queue_tick(32'd7000, 0);
    queue_tick(32'd7000, 0);
    // Longest fade across the time wrap, then a new command mid-fade
    queue_beat(MODE_CMD, RING_SIDE, 8'd10, 8'd20, 8'd30, 16'hFFFF, 32'hFFFF_FF00, 0);
    queue_tick(32'h0000_0010, 0);
    queue_beat(MODE_CMD, RING_SIDE, 8'd250, 8'd250, 8'd250, 16'd300, 32'h0000_0020, 0);
    queue_tick(32'h0000_0100, 0);
    // Time before the phase start reads as a very long wait
    queue_tick(32'h0000_0010, 0);

    // Random part: mostly command-then-ticks sequences, some noise
    clock_ms = 32'd10000;
    seq_no = 0;
    while (live_items < 1050) begin
      c = $urandom_range(0, 99);
      if (c < 15) begin
        queue_beat(1'($urandom), 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom), $urandom, 0);
      end else begin
        if ($urandom_range(0, 4) == 0) clock_ms = $urandom;
        else clock_ms = clock_ms + $urandom_range(0, 100);
        c = $urandom_range(0, 99);
        if (c < 10) f = 16'd0;
        else if (c < 25) f = 16'($urandom_range(1, 4));
        else if (c < 85) f = 16'($urandom_range(5, 300));
        else f = 16'($urandom);
        queue_beat(MODE_CMD, ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : RING_SIDE,
                   pick_level(), pick_level(), pick_level(), f, clock_ms,
                   (seq_no % 150) == 0);
        seq_no++;
        n_ticks = $urandom_range(1, 8);
        t = clock_ms;
        for (int k = 0; k < n_ticks; k++) begin
          if ($urandom_range(0, 7) == 0) t = t + $urandom;
          else t = t + $urandom_range(0, 32'(f) / 3 + 1);
          queue_tick(t, 0);
        end
        clock_ms = t;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (beat_q.size() == 0 && !in_valid && led_exp_q.size() == 0);
    repeat (50) @(posedge clk);
    if (led_exp_q.size() != 0)
      report_mismatch("results never delivered", led_exp_q.size(), 0);
    $display("Run covered %0d beats in and %0d results out: %0d LED writes, %0d split fades.",
             beats_in, results_seen, writes_seen, split_fades);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Timeout with %0d results still expected", led_exp_q.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
